FILE: rtl/core/fslm_pkg.sv
package fslm_pkg;

    localparam int MAX_PATTERN   = 16;
    localparam int COUNT_WIDTH   = 32;
    localparam int WINDOW_DEPTH  = MAX_PATTERN + 1;
    localparam int LEN_W         = $clog2(MAX_PATTERN + 1);
    localparam int POS_W         = $clog2(WINDOW_DEPTH + 1);
    localparam int WIN_IDX_W     = $clog2(WINDOW_DEPTH);
    localparam int PAT_W         = 8 * MAX_PATTERN;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 64;
    localparam int FIFO_DEPTH    = 4;
    localparam int FIFO_PTR_W    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W    = $clog2(FIFO_DEPTH + 1);
    localparam int OUT_DATA_W    = ((2 * COUNT_WIDTH + 1 + 7) / 8) * 8;

    localparam logic [7:0] CHAR_LF   = 8'h0A;
    localparam logic [7:0] CHAR_US   = 8'h5F;
    localparam logic [7:0] CHAR_LO_A = 8'h61;
    localparam logic [7:0] CHAR_LO_Z = 8'h7A;
    localparam logic [7:0] CHAR_UP_A = 8'h41;
    localparam logic [7:0] CHAR_UP_Z = 8'h5A;
    localparam logic [7:0] CHAR_D0   = 8'h30;
    localparam logic [7:0] CHAR_D9   = 8'h39;
    localparam logic [7:0] CASE_OFS  = CHAR_LO_A - CHAR_UP_A;

    localparam logic OP_DATA = 1'b0;
    localparam logic OP_EOF  = 1'b1;

    localparam logic KIND_REPORT  = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PAT_LOW    = 3'd0,
        REG_PAT_HIGH   = 3'd1,
        REG_PAT_LEN    = 3'd2,
        REG_FOLD_CASE  = 3'd3,
        REG_INVERT     = 3'd4,
        REG_WORD_ONLY  = 3'd5,
        REG_COUNT_MODE = 3'd6
    } t_cfg_reg;

    typedef struct packed {
        logic [PAT_W-1:0] pattern;
        logic [LEN_W-1:0] length;
        logic             fold_case;
        logic             invert;
        logic             word_only;
        logic             count_mode;
    } t_cfg;

    typedef struct packed {
        logic                   kind;
        logic [COUNT_WIDTH-1:0] line_number;
        logic [COUNT_WIDTH-1:0] selected_count;
        logic                   found_any;
        logic                   last;
    } t_result;

    typedef struct packed {
        logic [1:0] count;
        t_result    slot0;
        t_result    slot1;
    } t_emit;

    function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic en);
        logic [7:0] r;
        r = c;
        if (en && c >= CHAR_UP_A && c <= CHAR_UP_Z) r = c + CASE_OFS;
        return r;
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return (c >= CHAR_LO_A && c <= CHAR_LO_Z) || (c >= CHAR_UP_A && c <= CHAR_UP_Z) ||
               (c >= CHAR_D0 && c <= CHAR_D9) || (c == CHAR_US);
    endfunction

    function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
        return (v == '1) ? v : v + COUNT_WIDTH'(1);
    endfunction

endpackage

FILE: rtl/core/fslm_cfg_regs.sv
module fslm_cfg_regs
    import fslm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    logic [63:0]      r_pat_low;
    logic [63:0]      r_pat_high;
    logic [LEN_W-1:0] r_len;
    logic             r_fold_case;
    logic             r_invert;
    logic             r_word_only;
    logic             r_count_mode;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_low    <= '0;
            r_pat_high   <= '0;
            r_len        <= LEN_W'(1);
            r_fold_case  <= 1'b0;
            r_invert     <= 1'b0;
            r_word_only  <= 1'b0;
            r_count_mode <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_PAT_LOW:    r_pat_low    <= i_cfg_data[63:0];
                REG_PAT_HIGH:   r_pat_high   <= i_cfg_data[63:0];
                REG_PAT_LEN:    r_len        <= i_cfg_data[LEN_W-1:0];
                REG_FOLD_CASE:  r_fold_case  <= i_cfg_data[0];
                REG_INVERT:     r_invert     <= i_cfg_data[0];
                REG_WORD_ONLY:  r_word_only  <= i_cfg_data[0];
                REG_COUNT_MODE: r_count_mode <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        o_cfg.pattern    = {r_pat_high, r_pat_low};
        o_cfg.fold_case  = r_fold_case;
        o_cfg.invert     = r_invert;
        o_cfg.word_only  = r_word_only;
        o_cfg.count_mode = r_count_mode;
        // zero means one, anything above the maximum is clamped
        if (r_len == '0) begin
            o_cfg.length = LEN_W'(1);
        end else if (r_len > LEN_W'(MAX_PATTERN)) begin
            o_cfg.length = LEN_W'(MAX_PATTERN);
        end else begin
            o_cfg.length = r_len;
        end
    end

endmodule

FILE: rtl/core/fslm_match.sv
module fslm_match
    import fslm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_valid,
    input  logic       i_opcode,
    input  logic [7:0] i_byte,
    output t_emit      o_emit
);

    logic [7:0]             r_win [WINDOW_DEPTH];
    logic [POS_W-1:0]       r_pos;
    logic                   r_hit;
    logic                   r_pend;
    logic                   r_open;
    logic [COUNT_WIDTH-1:0] r_lines;
    logic [COUNT_WIDTH-1:0] r_sel;
    logic                   r_found;

    logic [7:0]             n_win [WINDOW_DEPTH];
    logic [POS_W-1:0]       n_pos;
    logic                   n_hit;
    logic                   n_pend;
    logic                   n_open;
    logic [COUNT_WIDTH-1:0] n_lines;
    logic [COUNT_WIDTH-1:0] n_sel;
    logic                   n_found;

    logic [POS_W-1:0]       pos_inc;
    logic [WIN_IDX_W-1:0]   v_idx;
    logic                   eq;
    logic                   full;
    logic                   bounded;
    logic                   fin_hit;
    logic                   fin_sel;
    logic [COUNT_WIDTH-1:0] fin_lines;
    logic [COUNT_WIDTH-1:0] fin_sel_cnt;
    logic                   fin_report;
    t_result                report;
    t_result                summary;

    always_comb begin
        n_win[0] = i_byte;
        for (int k = 1; k < WINDOW_DEPTH; k++) begin
            n_win[k] = r_win[k-1];
        end
        pos_inc = (r_pos < POS_W'(WINDOW_DEPTH)) ? r_pos + POS_W'(1) : r_pos;

        // parallel compare of the newest bytes against the pattern
        eq    = 1'b1;
        v_idx = '0;
        for (int i = 0; i < MAX_PATTERN; i++) begin
            if (LEN_W'(i) < i_cfg.length) begin
                v_idx = WIN_IDX_W'(i_cfg.length) - WIN_IDX_W'(1) - WIN_IDX_W'(i);
                if (fold_byte(n_win[v_idx], i_cfg.fold_case) !=
                    fold_byte(i_cfg.pattern[8*i +: 8], i_cfg.fold_case)) begin
                    eq = 1'b0;
                end
            end
        end
        full    = pos_inc >= POS_W'(i_cfg.length);
        bounded = !((pos_inc > POS_W'(i_cfg.length)) &&
                    is_word(n_win[WIN_IDX_W'(i_cfg.length)]));

        // line judgement
        fin_hit     = r_hit || r_pend;
        fin_lines   = sat_inc(r_lines);
        fin_sel     = fin_hit ^ i_cfg.invert;
        fin_sel_cnt = fin_sel ? sat_inc(r_sel) : r_sel;
        fin_report  = fin_sel && !i_cfg.count_mode;

        report.kind           = KIND_REPORT;
        report.line_number    = fin_lines;
        report.selected_count = fin_sel_cnt;
        report.found_any      = 1'b1;
        report.last           = 1'b1;

        n_pos   = r_pos;
        n_hit   = r_hit;
        n_pend  = r_pend;
        n_open  = r_open;
        n_lines = r_lines;
        n_sel   = r_sel;
        n_found = r_found;

        summary.kind           = KIND_SUMMARY;
        summary.line_number    = r_lines;
        summary.selected_count = r_sel;
        summary.found_any      = r_found;
        summary.last           = 1'b1;

        o_emit.count = 2'd0;
        o_emit.slot0 = report;
        o_emit.slot1 = summary;

        if (i_opcode == OP_EOF) begin
            if (r_open) begin
                summary.line_number    = fin_lines;
                summary.selected_count = fin_sel_cnt;
                summary.found_any      = r_found || fin_sel;
            end
            if (r_open && fin_report) begin
                o_emit.count      = 2'd2;
                o_emit.slot0      = report;
                o_emit.slot0.last = 1'b0;
                o_emit.slot1      = summary;
            end else begin
                o_emit.count = 2'd1;
                o_emit.slot0 = summary;
            end
            n_lines = '0;
            n_sel   = '0;
            n_found = 1'b0;
            n_pos   = '0;
            n_hit   = 1'b0;
            n_pend  = 1'b0;
            n_open  = 1'b0;
        end else if (i_byte == CHAR_LF) begin
            o_emit.count = fin_report ? 2'd1 : 2'd0;
            n_lines = fin_lines;
            n_sel   = fin_sel_cnt;
            n_found = r_found || fin_sel;
            n_pos   = '0;
            n_hit   = 1'b0;
            n_pend  = 1'b0;
            n_open  = 1'b0;
        end else begin
            n_hit  = r_hit || (r_pend && !is_word(i_byte));
            n_pend = 1'b0;
            n_pos  = pos_inc;
            n_open = 1'b1;
            if (full && eq) begin
                if (!i_cfg.word_only) begin
                    n_hit = 1'b1;
                end else if (bounded) begin
                    n_pend = 1'b1;
                end
            end
        end

        if (!i_valid) o_emit.count = 2'd0;
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && i_opcode == OP_DATA && i_byte != CHAR_LF) begin
            for (int k = 0; k < WINDOW_DEPTH; k++) begin
                r_win[k] <= n_win[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_hit   <= 1'b0;
            r_pend  <= 1'b0;
            r_open  <= 1'b0;
            r_lines <= '0;
            r_sel   <= '0;
            r_found <= 1'b0;
        end else if (i_valid) begin
            r_pos   <= n_pos;
            r_hit   <= n_hit;
            r_pend  <= n_pend;
            r_open  <= n_open;
            r_lines <= n_lines;
            r_sel   <= n_sel;
            r_found <= n_found;
        end
    end

endmodule

FILE: rtl/core/fslm_out_fifo.sv
module fslm_out_fifo
    import fslm_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_emit   i_emit,
    output logic    o_room,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_data
);

    t_result               r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr;
    logic [FIFO_PTR_W-1:0] r_rd;
    logic [FIFO_CNT_W-1:0] r_cnt;
    logic                  pop;

    // room for the largest burst of results from one item
    assign o_room  = r_cnt <= FIFO_CNT_W'(FIFO_DEPTH - 2);
    assign o_valid = r_cnt != '0;
    assign o_data  = r_mem[r_rd];
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (i_emit.count != 2'd0) r_mem[r_wr] <= i_emit.slot0;
        if (i_emit.count == 2'd2) r_mem[r_wr + FIFO_PTR_W'(1)] <= i_emit.slot1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + FIFO_PTR_W'(i_emit.count);
            r_rd  <= r_rd + FIFO_PTR_W'(pop);
            r_cnt <= r_cnt + FIFO_CNT_W'(i_emit.count) - FIFO_CNT_W'(pop);
        end
    end

endmodule

FILE: rtl/core/fixed_string_line_matcher_core.sv
// path: an input byte is registered, judged once the four-entry result queue has room,
// and its results are written to the queue and offered on the master side
// throughput: one item per cycle while the queue has room; end of file with an open line
// that is reported gives two results, drained one per cycle while m_axis_tready is high
// reset: synchronous active-low i_rst_n resets counters, line state, queue and config
module fixed_string_line_matcher_core
    import fslm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,  // text_byte
    input  logic                  s_axis_tuser,  // opcode
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,  // line_number, selected_count, found_any
    output logic                  m_axis_tuser,  // result_kind
    output logic                  m_axis_tlast   // last_of_run
);

    t_cfg    cfg;
    t_emit   emit;
    t_result res;
    logic    room;
    logic    consume;
    logic    r_in_valid;
    logic    r_in_op;
    logic [7:0] r_in_byte;

    assign consume       = r_in_valid && room;
    assign s_axis_tready = !r_in_valid || consume;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_op   <= s_axis_tuser;
            r_in_byte <= s_axis_tdata;
        end
    end

    fslm_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    fslm_match u_match (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_valid  (consume),
        .i_opcode (r_in_op),
        .i_byte   (r_in_byte),
        .o_emit   (emit)
    );

    fslm_out_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_emit  (emit),
        .o_room  (room),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (res)
    );

    assign m_axis_tdata = OUT_DATA_W'({res.found_any, res.selected_count, res.line_number});
    assign m_axis_tuser = res.kind;
    assign m_axis_tlast = res.last;

endmodule

FILE: sim/tb_fixed_string_line_matcher_core.sv
module tb_fixed_string_line_matcher_core;
    timeunit 1ns;
    timeprecision 1ps;

    import fslm_pkg::*;

    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 130;
    localparam int HOLD_PHASE  = 3;
    localparam int SETTLE      = 8;
    localparam int LONG_HOLD   = 400;
    localparam int IDLE_LIMIT  = 4000;
    localparam int REPORT_MAX  = 10;
    localparam int DIR_ROWS    = 35;

    localparam logic [7:0] TEXT_POOL [8] = '{"a", "b", "A", "B", "_", " ", "0", "."};

    typedef enum logic {ROW_CFG, ROW_ITEM} t_row_kind;
    typedef enum logic [1:0] {RX_FREE, RX_HALF, RX_SLOW, RX_BUSY} t_rx_mode;

    typedef struct packed {
        logic       op;
        logic [7:0] data;
    } t_text_item;

    typedef struct {
        t_row_kind             kind;
        t_cfg_reg              reg_idx;
        logic [CFG_DATA_W-1:0] value;
        logic                  op;
        logic [7:0]            data;
        int                    n_typed;
        t_result               typed_res;
    } t_stim_row;

    localparam t_result NO_RES = '0;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_valid   = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata  = '0;
    logic                  s_axis_tuser  = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  m_axis_tlast;

    fixed_string_line_matcher_core u_dut (.*);

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // matcher configuration as last written
    logic [8*MAX_PATTERN-1:0] cfg_pat;
    logic [4:0]               cfg_len;
    logic                     cfg_fold;
    logic                     cfg_invert;
    logic                     cfg_whole;
    logic                     cfg_count;

    // line and file state
    logic [7:0]             scan_window [WINDOW_DEPTH];
    int                     scan_fill;
    logic                   line_hit;
    logic                   ww_pending;
    logic                   line_open;
    logic [COUNT_WIDTH-1:0] lines_seen;
    logic [COUNT_WIDTH-1:0] lines_picked;
    logic                   any_picked;

    t_result    step_out [$];
    t_result    results_due [$];
    t_text_item phase_feed [$];
    t_stim_row  dir_tab [DIR_ROWS];

    int fail_count   = 0;
    int burst_left   = 0;
    int hold_reqs    = 0;
    int holds_done   = 0;
    int hold_left    = 0;
    int rx_left      = 0;
    int quiet_cycles = 0;
    t_rx_mode rx_mode = RX_FREE;

    function automatic logic word_ch(input logic [7:0] c);
        return (c >= CHAR_LO_A && c <= CHAR_LO_Z) || (c >= CHAR_UP_A && c <= CHAR_UP_Z) ||
               (c >= CHAR_D0 && c <= CHAR_D9) || c == CHAR_US;
    endfunction

    function automatic logic [7:0] fold_ch(input logic [7:0] c);
        if (cfg_fold && c >= CHAR_UP_A && c <= CHAR_UP_Z) begin
            return c + 8'd32;
        end
        return c;
    endfunction

    function automatic int eff_len();
        if (cfg_len == 0) begin
            return 1;
        end
        if (cfg_len > MAX_PATTERN) begin
            return MAX_PATTERN;
        end
        return int'(cfg_len);
    endfunction

    function automatic void clear_line();
        foreach (scan_window[k]) begin
            scan_window[k] = '0;
        end
        scan_fill  = 0;
        line_hit   = 1'b0;
        ww_pending = 1'b0;
        line_open  = 1'b0;
    endfunction

    function automatic void reset_model();
        cfg_pat      = '0;
        cfg_len      = 5'd1;
        cfg_fold     = 1'b0;
        cfg_invert   = 1'b0;
        cfg_whole    = 1'b0;
        cfg_count    = 1'b0;
        lines_seen   = '0;
        lines_picked = '0;
        any_picked   = 1'b0;
        clear_line();
    endfunction

    function automatic void apply_reg(input t_cfg_reg idx, input logic [CFG_DATA_W-1:0] val);
        unique case (idx)
            REG_PAT_LOW:    cfg_pat[63:0]   = val;
            REG_PAT_HIGH:   cfg_pat[127:64] = val;
            REG_PAT_LEN:    cfg_len         = val[4:0];
            REG_FOLD_CASE:  cfg_fold        = val[0];
            REG_INVERT:     cfg_invert      = val[0];
            REG_WORD_ONLY:  cfg_whole       = val[0];
            REG_COUNT_MODE: cfg_count       = val[0];
            default: ;
        endcase
    endfunction

    function automatic void scan_byte(input logic [7:0] c);
        int   len;
        logic same;
        len  = eff_len();
        same = 1'b1;
        if (ww_pending) begin
            if (!word_ch(c)) begin
                line_hit = 1'b1;
            end
            ww_pending = 1'b0;
        end
        for (int k = WINDOW_DEPTH - 1; k > 0; k--) begin
            scan_window[k] = scan_window[k-1];
        end
        scan_window[0] = c;
        if (scan_fill < WINDOW_DEPTH) begin
            scan_fill++;
        end
        line_open = 1'b1;
        if (scan_fill >= len) begin
            for (int k = 0; k < len; k++) begin
                if (fold_ch(scan_window[len-1-k]) != fold_ch(cfg_pat[8*k +: 8])) begin
                    same = 1'b0;
                end
            end
            if (same) begin
                if (!cfg_whole) begin
                    line_hit = 1'b1;
                end else if (!(scan_fill > len && word_ch(scan_window[len]))) begin
                    ww_pending = 1'b1;
                end
            end
        end
    endfunction

    function automatic void close_line();
        logic hit;
        hit = line_hit | ww_pending;
        if (lines_seen != '1) begin
            lines_seen++;
        end
        if (hit != cfg_invert) begin
            if (lines_picked != '1) begin
                lines_picked++;
            end
            any_picked = 1'b1;
            if (!cfg_count) begin
                step_out.push_back(t_result'{KIND_REPORT, lines_seen, lines_picked, 1'b1, 1'b0});
            end
        end
        clear_line();
    endfunction

    function automatic void grep_step(input logic op, input logic [7:0] c);
        step_out.delete();
        if (op == OP_DATA) begin
            if (c == CHAR_LF) begin
                close_line();
            end else begin
                scan_byte(c);
            end
        end else begin
            if (line_open) begin
                close_line();
            end
            step_out.push_back(t_result'{KIND_SUMMARY, lines_seen, lines_picked, any_picked, 1'b0});
            lines_seen   = '0;
            lines_picked = '0;
            any_picked   = 1'b0;
            clear_line();
        end
        if (step_out.size() != 0) begin
            step_out[step_out.size()-1].last = 1'b1;
        end
    endfunction

    function automatic t_result one_result(input logic kind, input logic [31:0] line_no,
                                           input logic [31:0] picked, input logic found);
        return t_result'{kind, line_no, picked, found, 1'b1};
    endfunction

    function automatic t_stim_row item_row(input logic op, input logic [7:0] data,
                                           input int n_typed = -1, input t_result res = NO_RES);
        t_stim_row row;
        row.kind      = ROW_ITEM;
        row.reg_idx   = REG_PAT_LOW;
        row.value     = '0;
        row.op        = op;
        row.data      = data;
        row.n_typed   = n_typed;
        row.typed_res = res;
        return row;
    endfunction

    function automatic t_stim_row reg_row(input t_cfg_reg idx, input logic [CFG_DATA_W-1:0] val);
        t_stim_row row;
        row           = item_row(OP_DATA, '0);
        row.kind      = ROW_CFG;
        row.reg_idx   = idx;
        row.value     = val;
        return row;
    endfunction

    function automatic void make_line();
        int         n;
        int         r;
        int         len;
        logic [7:0] c;
        n   = $urandom_range(0, 20);
        len = eff_len();
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            if (r < 15) begin
                for (int j = 0; j < len; j++) begin
                    c = cfg_pat[8*j +: 8];
                    if ((c | 8'h20) >= CHAR_LO_A && (c | 8'h20) <= CHAR_LO_Z &&
                        $urandom_range(0, 2) == 0) begin
                        c = c ^ 8'h20;
                    end
                    phase_feed.push_back('{OP_DATA, c});
                end
            end else if (r < 85) begin
                phase_feed.push_back('{OP_DATA, TEXT_POOL[$urandom_range(0, 7)]});
            end else begin
                phase_feed.push_back('{OP_DATA, 8'($urandom_range(0, 255))});
            end
        end
        r = $urandom_range(0, 99);
        if (r < 93) begin
            phase_feed.push_back('{OP_DATA, CHAR_LF});
        end
        if (r >= 85) begin
            phase_feed.push_back('{OP_EOF, 8'($urandom_range(0, 255))});
        end
    endfunction

    function automatic string fmt_result(input t_result r);
        return $sformatf("kind %0d line %0d count %0d found %0d last %0d",
                         r.kind, r.line_number, r.selected_count, r.found_any, r.last);
    endfunction

    task automatic write_reg(input t_cfg_reg idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        apply_reg(idx, val);
    endtask

    task automatic settle_block();
        while (results_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic send_item(input logic op, input logic [7:0] c, input int n_typed,
                             input t_result res);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
            gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tuser  <= op;
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
        burst_left--;
        grep_step(op, c);
        if (n_typed < 0) begin
            foreach (step_out[k]) begin
                results_due.push_back(step_out[k]);
            end
        end else if (n_typed > 0) begin
            results_due.push_back(res);
        end
    endtask

    task automatic load_phase_config(input int phase);
        logic [8*MAX_PATTERN-1:0] pat;
        logic [4:0]               len;
        logic [3:0]               flags;
        int                       r;
        if (phase == 0) begin
            pat   = '1;
            len   = '1;
            flags = '1;
        end else if (phase == 1) begin
            pat   = '0;
            len   = '0;
            flags = '0;
        end else begin
            for (int k = 0; k < MAX_PATTERN; k++) begin
                pat[8*k +: 8] = ($urandom_range(0, 9) < 7) ? TEXT_POOL[$urandom_range(0, 7)]
                                                           : 8'($urandom_range(0, 255));
            end
            r = $urandom_range(0, 99);
            if (r < 55) begin
                len = 5'($urandom_range(1, 3));
            end else if (r < 85) begin
                len = 5'($urandom_range(4, 16));
            end else begin
                len = ($urandom_range(0, 1) == 0) ? 5'd0 : 5'($urandom_range(17, 31));
            end
            flags = 4'($urandom_range(0, 15));
            if ($urandom_range(0, 2) != 0) begin
                flags[3] = 1'b0;
            end
        end
        write_reg(REG_PAT_LOW, pat[63:0]);
        write_reg(REG_PAT_HIGH, pat[127:64]);
        write_reg(REG_PAT_LEN, 64'(len));
        write_reg(REG_FOLD_CASE, 64'(flags[0]));
        write_reg(REG_INVERT, 64'(flags[1]));
        write_reg(REG_WORD_ONLY, 64'(flags[2]));
        write_reg(REG_COUNT_MODE, 64'(flags[3]));
        i_cfg_valid <= 1'b0;
    endtask

    // result side: stall pattern plus one long hold on request
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end else if (holds_done != hold_reqs) begin
            m_axis_tready <= 1'b0;
            hold_left     <= LONG_HOLD;
            holds_done    <= holds_done + 1;
        end else begin
            if (rx_left == 0) begin
                rx_mode <= t_rx_mode'($urandom_range(0, 3));
                rx_left <= $urandom_range(4, 64);
            end else begin
                rx_left <= rx_left - 1;
            end
            unique case (rx_mode)
                RX_FREE: m_axis_tready <= 1'b1;
                RX_HALF: m_axis_tready <= 1'($urandom_range(0, 1));
                RX_SLOW: m_axis_tready <= ($urandom_range(0, 9) == 0);
                default: m_axis_tready <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_result'{m_axis_tuser, m_axis_tdata[COUNT_WIDTH-1:0],
                            m_axis_tdata[2*COUNT_WIDTH-1:COUNT_WIDTH],
                            m_axis_tdata[2*COUNT_WIDTH], m_axis_tlast};
            if (results_due.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_MAX) begin
                    $display("unexpected result transaction: %s", fmt_result(got));
                end
            end else begin
                want = results_due.pop_front();
                if (got.kind !== want.kind || got.line_number !== want.line_number ||
                    got.selected_count !== want.selected_count ||
                    got.found_any !== want.found_any || got.last !== want.last) begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX) begin
                        $display("mismatch: expected %s, got %s",
                                 fmt_result(want), fmt_result(got));
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == IDLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        reset_model();
        dir_tab = '{
            item_row(OP_EOF, 8'hFF, 1, one_result(KIND_SUMMARY, 0, 0, 1'b0)),
            item_row(OP_DATA, "a", 0),
            item_row(OP_DATA, CHAR_LF, 0),
            item_row(OP_DATA, 8'h00, 0),
            item_row(OP_DATA, CHAR_LF, 1, one_result(KIND_REPORT, 2, 1, 1'b1)),
            item_row(OP_DATA, 8'hFF, 0),
            item_row(OP_EOF, 8'h00, 1, one_result(KIND_SUMMARY, 3, 1, 1'b1)),
            reg_row(REG_PAT_LOW, 64'h74_61_63),
            reg_row(REG_PAT_LEN, 64'd3),
            reg_row(REG_FOLD_CASE, 64'd1),
            reg_row(REG_WORD_ONLY, 64'd1),
            item_row(OP_DATA, "C"),
            item_row(OP_DATA, "A"),
            item_row(OP_DATA, "T"),
            item_row(OP_DATA, "s"),
            item_row(OP_DATA, CHAR_LF),
            item_row(OP_DATA, "."),
            item_row(OP_DATA, "c"),
            item_row(OP_DATA, "a"),
            item_row(OP_DATA, "T"),
            item_row(OP_EOF, 8'h5A),
            reg_row(REG_PAT_HIGH, 64'hFFFF_FFFF_FFFF_FFFF),
            reg_row(REG_PAT_LEN, 64'd0),
            reg_row(REG_INVERT, 64'd1),
            reg_row(REG_COUNT_MODE, 64'd1),
            reg_row(REG_WORD_ONLY, 64'd0),
            item_row(OP_DATA, "x"),
            item_row(OP_DATA, CHAR_LF),
            item_row(OP_DATA, "c"),
            item_row(OP_DATA, "b"),
            reg_row(REG_COUNT_MODE, 64'd0),
            reg_row(REG_PAT_LEN, 64'd31),
            item_row(OP_DATA, CHAR_LF),
            item_row(OP_DATA, "Z"),
            item_row(OP_EOF, 8'h00)
        };
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++) begin
            if (dir_tab[i].kind == ROW_CFG) begin
                if (i == 0 || dir_tab[i-1].kind != ROW_CFG) begin
                    s_axis_tvalid <= 1'b0;
                    settle_block();
                end
                write_reg(dir_tab[i].reg_idx, dir_tab[i].value);
                if (i == DIR_ROWS - 1 || dir_tab[i+1].kind != ROW_CFG) begin
                    i_cfg_valid <= 1'b0;
                end
            end else begin
                send_item(dir_tab[i].op, dir_tab[i].data, dir_tab[i].n_typed,
                          dir_tab[i].typed_res);
            end
        end

        for (int phase = 0; phase < PHASES; phase++) begin
            s_axis_tvalid <= 1'b0;
            settle_block();
            load_phase_config(phase);
            if (phase == HOLD_PHASE) begin
                hold_reqs <= hold_reqs + 1;
            end
            phase_feed.delete();
            while (phase_feed.size() < PHASE_ITEMS) begin
                make_line();
            end
            foreach (phase_feed[k]) begin
                send_item(phase_feed[k].op, phase_feed[k].data, -1, NO_RES);
            end
        end

        s_axis_tvalid <= 1'b0;
        settle_block();
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
